// File: rtl/core/spmd_pkg.sv
`timescale 1ns / 1ps
// spmd_pkg: widths, types, command and status structs for the segment pair distance unit
// no dependencies

package spmd_pkg;

    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 20;
    localparam int MAX_ROUNDS = 32;
    localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);

    localparam int DEL_W  = 17;
    localparam int ZC_W   = 30;
    localparam int RAT_W  = FRAC_W + 1;
    localparam int R_W    = RAT_W + 1;
    localparam int DSE_W  = COORD_W + 1;
    localparam int PROD_W = DSE_W + R_W;
    localparam int P_W    = PROD_W + 3;
    localparam int U_W    = P_W - 1;
    localparam int L_W    = (U_W + 1) / 2;
    localparam int H_W    = U_W - L_W;
    localparam int ACC_W  = 2 * U_W;
    localparam int DIST_W = 64;
    localparam int SQ_W   = 54;
    localparam int CEIL_W = 17;
    localparam int ROOT_W = CEIL_W + 1;
    localparam int X_W    = SQ_W - FRAC_W;
    localparam int K_W    = $clog2(ROOT_W);

    localparam logic [RAT_W-1:0] ONE_Q = RAT_W'(1) << FRAC_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord t_cvec [3];
    typedef logic signed [P_W-1:0] t_pq;
    typedef t_pq t_pvec [3];

    typedef enum logic [2:0] {
        R_MID, R_UP, R_DN, R_ONE, R_ZERO
    } t_rsel;

    typedef enum logic [1:0] {
        M_HOLD, M_BS, M_BE, M_PT
    } t_msel;

    typedef enum logic [1:0] {
        DST_NONE, DST_C, DST_UP, DST_DN
    } t_dst;

    typedef enum logic [4:0] {
        S_IDLE, S_EP_SET, S_EP_START, S_EP_WAIT, S_EP_MIN, S_RND_INIT,
        S_SRCH_INIT, S_MID, S_MID_WAIT, S_UP_START, S_UP_WAIT, S_DN_START,
        S_DN_WAIT, S_DECIDE, S_FIN_START, S_FIN_WAIT, S_PT_A, S_RND_CHK,
        S_ROOT_START, S_ROOT_WAIT, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        DP_IDLE, DP_MUL, DP_DIF, DP_SQ0, DP_SQ1, DP_SQ2, DP_ADD
    } t_dphase;

    typedef enum logic [1:0] {
        RT_IDLE, RT_BIT, RT_FIX
    } t_rphase;

    typedef struct packed {
        logic  capture;
        t_msel msel;
        logic  eval_start;
        logic  seg;
        t_rsel rsel;
        t_dst  dst;
        logic  search_init;
        logic  search_step;
        logic  best_load;
        logic  best_min;
        logic  root_start;
        logic  out_load;
        logic  exhausted;
    } t_dp_cmd;

    typedef struct packed {
        logic eval_busy;
        logic eval_done;
        logic stop_now;
        logic flat;
        logic c_lt_best;
        logic root_done;
        logic out_busy;
    } t_dp_sts;

    function automatic t_pq coord_to_q(input t_coord c);
        coord_to_q = {{(P_W - COORD_W - FRAC_W){c[COORD_W-1]}}, c, {FRAC_W{1'b0}}};
    endfunction

endpackage

// File: rtl/core/spmd_dist.sv
`timescale 1ns / 1ps
// spmd_dist: squared distance from a blended point on a segment to a held point,
// six steps per axis; uses spmd_pkg

module spmd_dist (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  spmd_pkg::t_cvec            i_seg_s,
    input  spmd_pkg::t_cvec            i_seg_e,
    input  logic signed [spmd_pkg::R_W-1:0] i_ratio,
    input  spmd_pkg::t_pvec            i_m,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [spmd_pkg::DIST_W-1:0] o_dist,
    output spmd_pkg::t_pvec            o_pt
);

    spmd_pkg::t_dphase r_phase, n_phase;
    logic signed [spmd_pkg::DSE_W-1:0]  r_dse [3];
    spmd_pkg::t_cvec                    r_e;
    logic signed [spmd_pkg::R_W-1:0]    r_ratio;
    logic [1:0]                         r_ax;
    logic signed [spmd_pkg::PROD_W-1:0] r_prod;
    logic [spmd_pkg::U_W-1:0]           r_u;
    logic [spmd_pkg::ACC_W-1:0]         r_acc;
    logic [spmd_pkg::DIST_W-1:0]        r_sum;
    spmd_pkg::t_pvec                    r_pt;
    logic                               r_done;

    logic signed [spmd_pkg::DSE_W-1:0]  w_dse;
    logic signed [spmd_pkg::PROD_W-1:0] w_mul;
    spmd_pkg::t_pq                      w_p;
    spmd_pkg::t_pq                      w_dif;
    spmd_pkg::t_pq                      w_abs;
    logic [spmd_pkg::H_W-1:0]           w_h;
    logic [spmd_pkg::L_W-1:0]           w_l;
    logic [2*spmd_pkg::H_W-1:0]         w_hh;
    logic [spmd_pkg::H_W+spmd_pkg::L_W-1:0] w_hl;
    logic [2*spmd_pkg::L_W-1:0]         w_ll;

    always_comb begin
        w_dse = r_dse[r_ax];
        w_mul = w_dse * r_ratio;
        w_p   = spmd_pkg::coord_to_q(r_e[r_ax]) + spmd_pkg::P_W'(r_prod);
        w_dif = w_p - i_m[r_ax];
        w_abs = w_dif[spmd_pkg::P_W-1] ? -w_dif : w_dif;
        w_h   = r_u[spmd_pkg::U_W-1:spmd_pkg::L_W];
        w_l   = r_u[spmd_pkg::L_W-1:0];
        w_hh  = w_h * w_h;
        w_hl  = w_h * w_l;
        w_ll  = w_l * w_l;
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            spmd_pkg::DP_IDLE: if (i_start) n_phase = spmd_pkg::DP_MUL;
            spmd_pkg::DP_MUL:  n_phase = spmd_pkg::DP_DIF;
            spmd_pkg::DP_DIF:  n_phase = spmd_pkg::DP_SQ0;
            spmd_pkg::DP_SQ0:  n_phase = spmd_pkg::DP_SQ1;
            spmd_pkg::DP_SQ1:  n_phase = spmd_pkg::DP_SQ2;
            spmd_pkg::DP_SQ2:  n_phase = spmd_pkg::DP_ADD;
            spmd_pkg::DP_ADD:  n_phase = (r_ax == 2'd2) ? spmd_pkg::DP_IDLE : spmd_pkg::DP_MUL;
            default:           n_phase = spmd_pkg::DP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spmd_pkg::DP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == spmd_pkg::DP_ADD) && (r_ax == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            spmd_pkg::DP_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_dse[i] <= spmd_pkg::DSE_W'(i_seg_s[i]) - spmd_pkg::DSE_W'(i_seg_e[i]);
                        r_e[i]   <= i_seg_e[i];
                    end
                    r_ratio <= i_ratio;
                    r_ax    <= 2'd0;
                    r_sum   <= '0;
                end
            end
            spmd_pkg::DP_MUL: r_prod <= w_mul;
            spmd_pkg::DP_DIF: begin
                r_pt[r_ax] <= w_p;
                r_u        <= w_abs[spmd_pkg::U_W-1:0];
            end
            spmd_pkg::DP_SQ0: r_acc <= spmd_pkg::ACC_W'(w_hh) << (2 * spmd_pkg::L_W);
            spmd_pkg::DP_SQ1: r_acc <= r_acc + (spmd_pkg::ACC_W'(w_hl) << (spmd_pkg::L_W + 1));
            spmd_pkg::DP_SQ2: r_acc <= r_acc + spmd_pkg::ACC_W'(w_ll);
            spmd_pkg::DP_ADD: begin
                r_sum <= r_sum + spmd_pkg::DIST_W'(r_acc >> spmd_pkg::FRAC_W);
                r_ax  <= r_ax + 2'd1;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_phase != spmd_pkg::DP_IDLE);
    assign o_done = r_done;
    assign o_dist = r_sum;
    assign o_pt   = r_pt;

endmodule

// File: rtl/core/spmd_root.sv
`timescale 1ns / 1ps
// spmd_root: ceiling of the square root of a Q.FRAC value, one result bit per cycle
// uses spmd_pkg

module spmd_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [spmd_pkg::SQ_W-1:0]   i_v,
    output logic                        o_done,
    output logic [spmd_pkg::CEIL_W-1:0] o_root
);

    spmd_pkg::t_rphase r_phase, n_phase;
    logic [spmd_pkg::X_W-1:0]    r_x;
    logic                        r_fnz;
    logic [spmd_pkg::ROOT_W-1:0] r_res;
    logic [spmd_pkg::K_W-1:0]    r_k;
    logic                        r_done;

    logic [spmd_pkg::ROOT_W-1:0]   w_trial;
    logic [spmd_pkg::ROOT_W-1:0]   w_op;
    logic [2*spmd_pkg::ROOT_W-1:0] w_sq;
    logic [2*spmd_pkg::ROOT_W-1:0] w_x;

    always_comb begin
        w_trial = r_res | (spmd_pkg::ROOT_W'(1) << r_k);
        w_op    = (r_phase == spmd_pkg::RT_FIX) ? r_res : w_trial;
        w_sq    = w_op * w_op;
        w_x     = (2 * spmd_pkg::ROOT_W)'(r_x);
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            spmd_pkg::RT_IDLE: if (i_start) n_phase = spmd_pkg::RT_BIT;
            spmd_pkg::RT_BIT:  if (r_k == '0) n_phase = spmd_pkg::RT_FIX;
            spmd_pkg::RT_FIX:  n_phase = spmd_pkg::RT_IDLE;
            default:           n_phase = spmd_pkg::RT_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spmd_pkg::RT_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == spmd_pkg::RT_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            spmd_pkg::RT_IDLE: begin
                if (i_start) begin
                    r_x   <= i_v[spmd_pkg::SQ_W-1:spmd_pkg::FRAC_W];
                    r_fnz <= |i_v[spmd_pkg::FRAC_W-1:0];
                    r_res <= '0;
                    r_k   <= spmd_pkg::K_W'(spmd_pkg::ROOT_W - 1);
                end
            end
            spmd_pkg::RT_BIT: begin
                if (w_sq <= w_x) r_res <= w_trial;
                r_k <= r_k - 1'b1;
            end
            spmd_pkg::RT_FIX: begin
                // round up unless the root is exact
                if ((w_sq != w_x) || r_fnz) r_res <= r_res + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_root = r_res[spmd_pkg::CEIL_W-1:0];

endmodule

// File: rtl/core/spmd_datapath.sv
`timescale 1ns / 1ps
// spmd_datapath: segment registers, held point, bisection bounds, best value, output register
// uses spmd_pkg, spmd_dist, spmd_root

module spmd_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spmd_pkg::t_dp_cmd           i_cmd,
    output spmd_pkg::t_dp_sts           o_sts,
    input  spmd_pkg::t_cvec             i_a_s,
    input  spmd_pkg::t_cvec             i_a_e,
    input  spmd_pkg::t_cvec             i_b_s,
    input  spmd_pkg::t_cvec             i_b_e,
    input  logic [spmd_pkg::DEL_W-1:0]  i_delta,
    input  logic [spmd_pkg::ZC_W-1:0]   i_zc,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [spmd_pkg::SQ_W-1:0]   o_min_sq,
    output logic [spmd_pkg::CEIL_W-1:0] o_ceil,
    output logic                        o_exh
);

    spmd_pkg::t_cvec r_as, r_ae, r_bs, r_be;
    spmd_pkg::t_pvec r_m;
    logic [spmd_pkg::RAT_W-1:0]  r_lo, r_hi;
    logic [spmd_pkg::DIST_W-1:0] r_c, r_up, r_dn, r_best;
    logic                        r_ovalid;
    logic [spmd_pkg::SQ_W-1:0]   r_osq;
    logic [spmd_pkg::CEIL_W-1:0] r_oceil;
    logic                        r_oexh;

    spmd_pkg::t_cvec                   w_seg_s, w_seg_e;
    spmd_pkg::t_pvec                   w_pt;
    logic [spmd_pkg::RAT_W:0]          w_lohi;
    logic [spmd_pkg::RAT_W-1:0]        w_mid;
    logic [spmd_pkg::DEL_W-1:0]        w_d;
    logic signed [spmd_pkg::R_W-1:0]   w_ratio;
    logic                              w_eval_busy, w_eval_done;
    logic [spmd_pkg::DIST_W-1:0]       w_dist;
    logic                              w_root_done;
    logic [spmd_pkg::CEIL_W-1:0]       w_root;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_seg_s[i] = i_cmd.seg ? r_bs[i] : r_as[i];
            w_seg_e[i] = i_cmd.seg ? r_be[i] : r_ae[i];
        end
        w_lohi = {1'b0, r_lo} + {1'b0, r_hi};
        w_mid  = w_lohi[spmd_pkg::RAT_W:1];
        w_d    = (i_delta == '0) ? spmd_pkg::DEL_W'(1) : i_delta;
        case (i_cmd.rsel)
            spmd_pkg::R_MID:  w_ratio = spmd_pkg::R_W'(w_mid);
            spmd_pkg::R_UP:   w_ratio = spmd_pkg::R_W'(w_mid) + spmd_pkg::R_W'(w_d);
            spmd_pkg::R_DN:   w_ratio = spmd_pkg::R_W'(w_mid) - spmd_pkg::R_W'(w_d);
            spmd_pkg::R_ONE:  w_ratio = spmd_pkg::R_W'(spmd_pkg::ONE_Q);
            spmd_pkg::R_ZERO: w_ratio = '0;
            default:          w_ratio = '0;
        endcase
    end

    spmd_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.eval_start),
        .i_seg_s (w_seg_s),
        .i_seg_e (w_seg_e),
        .i_ratio (w_ratio),
        .i_m     (r_m),
        .o_busy  (w_eval_busy),
        .o_done  (w_eval_done),
        .o_dist  (w_dist),
        .o_pt    (w_pt)
    );

    spmd_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_v     (r_best[spmd_pkg::SQ_W-1:0]),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_as <= i_a_s;
            r_ae <= i_a_e;
            r_bs <= i_b_s;
            r_be <= i_b_e;
        end
        case (i_cmd.msel)
            spmd_pkg::M_BS: for (int i = 0; i < 3; i++) r_m[i] <= spmd_pkg::coord_to_q(r_bs[i]);
            spmd_pkg::M_BE: for (int i = 0; i < 3; i++) r_m[i] <= spmd_pkg::coord_to_q(r_be[i]);
            spmd_pkg::M_PT: r_m <= w_pt;
            default: ;
        endcase
        if (w_eval_done) begin
            case (i_cmd.dst)
                spmd_pkg::DST_C:  r_c  <= w_dist;
                spmd_pkg::DST_UP: r_up <= w_dist;
                spmd_pkg::DST_DN: r_dn <= w_dist;
                default: ;
            endcase
        end
        if (i_cmd.search_init) begin
            r_lo <= '0;
            r_hi <= spmd_pkg::ONE_Q;
        end else if (i_cmd.search_step) begin
            if (r_c > r_up) r_lo <= w_mid;
            else            r_hi <= w_mid;
        end
        if (i_cmd.best_load || (i_cmd.best_min && (r_c < r_best))) r_best <= r_c;
        if (i_cmd.out_load) begin
            r_osq   <= r_best[spmd_pkg::SQ_W-1:0];
            r_oceil <= (r_best < spmd_pkg::DIST_W'(i_zc)) ? '0 : w_root;
            r_oexh  <= i_cmd.exhausted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.eval_busy = w_eval_busy;
        o_sts.eval_done = w_eval_done;
        o_sts.stop_now  = ({1'b0, r_lo} + spmd_pkg::RAT_W'(w_d)) >= {1'b0, r_hi};
        o_sts.flat      = (r_c <= r_up) && (r_c <= r_dn);
        o_sts.c_lt_best = (r_c < r_best);
        o_sts.root_done = w_root_done;
        o_sts.out_busy  = r_ovalid && !i_ready;
    end

    assign o_valid  = r_ovalid;
    assign o_min_sq = r_osq;
    assign o_ceil   = r_oceil;
    assign o_exh    = r_oexh;

endmodule

// File: rtl/core/spmd_ctrl.sv
`timescale 1ns / 1ps
// spmd_ctrl: sequencer for endpoint seeding, alternating bisection searches and rounding
// uses spmd_pkg

module spmd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output spmd_pkg::t_dp_cmd o_cmd,
    input  spmd_pkg::t_dp_sts i_sts
);

    spmd_pkg::t_state r_state, n_state;
    logic [1:0]                     r_ep, n_ep;
    logic [spmd_pkg::ROUND_W-1:0]   r_round, n_round;
    logic                           r_seg, n_seg;
    logic                           r_exh, n_exh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spmd_pkg::S_IDLE;
            r_ep    <= '0;
            r_round <= '0;
            r_seg   <= 1'b0;
            r_exh   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ep    <= n_ep;
            r_round <= n_round;
            r_seg   <= n_seg;
            r_exh   <= n_exh;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ep    = r_ep;
        n_round = r_round;
        n_seg   = r_seg;
        n_exh   = r_exh;
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.seg       = r_seg;
        o_cmd.exhausted = r_exh;
        case (r_state)
            spmd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_ep    = '0;
                    n_seg   = 1'b0;
                    n_state = spmd_pkg::S_EP_SET;
                end
            end
            spmd_pkg::S_EP_SET: begin
                o_cmd.msel = r_ep[0] ? spmd_pkg::M_BE : spmd_pkg::M_BS;
                n_state    = spmd_pkg::S_EP_START;
            end
            spmd_pkg::S_EP_START: begin
                o_cmd.eval_start = 1'b1;
                o_cmd.rsel       = r_ep[1] ? spmd_pkg::R_ZERO : spmd_pkg::R_ONE;
                n_state          = spmd_pkg::S_EP_WAIT;
            end
            spmd_pkg::S_EP_WAIT: begin
                o_cmd.dst = spmd_pkg::DST_C;
                if (i_sts.eval_done) n_state = spmd_pkg::S_EP_MIN;
            end
            spmd_pkg::S_EP_MIN: begin
                if (r_ep == 2'd0) o_cmd.best_load = 1'b1;
                else              o_cmd.best_min  = 1'b1;
                n_ep    = r_ep + 2'd1;
                n_state = (r_ep == 2'd3) ? spmd_pkg::S_RND_INIT : spmd_pkg::S_EP_SET;
            end
            spmd_pkg::S_RND_INIT: begin
                o_cmd.msel = spmd_pkg::M_BS;
                n_round    = '0;
                n_seg      = 1'b0;
                n_state    = spmd_pkg::S_SRCH_INIT;
            end
            spmd_pkg::S_SRCH_INIT: begin
                o_cmd.search_init = 1'b1;
                n_state           = spmd_pkg::S_MID;
            end
            spmd_pkg::S_MID: begin
                if (i_sts.stop_now) begin
                    n_state = spmd_pkg::S_FIN_START;
                end else begin
                    o_cmd.eval_start = 1'b1;
                    o_cmd.rsel       = spmd_pkg::R_MID;
                    n_state          = spmd_pkg::S_MID_WAIT;
                end
            end
            spmd_pkg::S_MID_WAIT: begin
                o_cmd.dst = spmd_pkg::DST_C;
                if (i_sts.eval_done) n_state = spmd_pkg::S_UP_START;
            end
            spmd_pkg::S_UP_START: begin
                o_cmd.eval_start = 1'b1;
                o_cmd.rsel       = spmd_pkg::R_UP;
                n_state          = spmd_pkg::S_UP_WAIT;
            end
            spmd_pkg::S_UP_WAIT: begin
                o_cmd.dst = spmd_pkg::DST_UP;
                if (i_sts.eval_done) n_state = spmd_pkg::S_DN_START;
            end
            spmd_pkg::S_DN_START: begin
                o_cmd.eval_start = 1'b1;
                o_cmd.rsel       = spmd_pkg::R_DN;
                n_state          = spmd_pkg::S_DN_WAIT;
            end
            spmd_pkg::S_DN_WAIT: begin
                o_cmd.dst = spmd_pkg::DST_DN;
                if (i_sts.eval_done) n_state = spmd_pkg::S_DECIDE;
            end
            spmd_pkg::S_DECIDE: begin
                if (i_sts.flat) begin
                    n_state = spmd_pkg::S_FIN_START;
                end else begin
                    o_cmd.search_step = 1'b1;
                    n_state           = spmd_pkg::S_MID;
                end
            end
            spmd_pkg::S_FIN_START: begin
                // blend the point at the chosen ratio
                o_cmd.eval_start = 1'b1;
                o_cmd.rsel       = spmd_pkg::R_MID;
                n_state          = spmd_pkg::S_FIN_WAIT;
            end
            spmd_pkg::S_FIN_WAIT: begin
                o_cmd.dst = spmd_pkg::DST_C;
                if (i_sts.eval_done) n_state = r_seg ? spmd_pkg::S_RND_CHK : spmd_pkg::S_PT_A;
            end
            spmd_pkg::S_PT_A: begin
                o_cmd.msel = spmd_pkg::M_PT;
                n_seg      = 1'b1;
                n_state    = spmd_pkg::S_SRCH_INIT;
            end
            spmd_pkg::S_RND_CHK: begin
                if (i_sts.c_lt_best) begin
                    o_cmd.best_load = 1'b1;
                    o_cmd.msel      = spmd_pkg::M_PT;
                    if (r_round == spmd_pkg::ROUND_W'(spmd_pkg::MAX_ROUNDS - 1)) begin
                        n_exh   = 1'b1;
                        n_state = spmd_pkg::S_ROOT_START;
                    end else begin
                        n_round = r_round + 1'b1;
                        n_seg   = 1'b0;
                        n_state = spmd_pkg::S_SRCH_INIT;
                    end
                end else begin
                    n_exh   = 1'b0;
                    n_state = spmd_pkg::S_ROOT_START;
                end
            end
            spmd_pkg::S_ROOT_START: begin
                o_cmd.root_start = 1'b1;
                n_state          = spmd_pkg::S_ROOT_WAIT;
            end
            spmd_pkg::S_ROOT_WAIT: begin
                if (i_sts.root_done) n_state = spmd_pkg::S_OUT;
            end
            spmd_pkg::S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = spmd_pkg::S_IDLE;
                end
            end
            default: n_state = spmd_pkg::S_IDLE;
        endcase
    end

    a_eval_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval_start |-> !i_sts.eval_busy)
        else $error("distance unit started while busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("output register overwritten before transfer");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= spmd_pkg::ROUND_W'(spmd_pkg::MAX_ROUNDS - 1))
        else $error("round counter beyond limit");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == spmd_pkg::S_EP_SET) && !o_in_ready)
        else $error("input taken while an item is in work");

endmodule

// File: rtl/core/segment_pair_min_distance_unit.sv
`timescale 1ns / 1ps
// segment_pair_min_distance_unit: top level, stream ports, register port, core wiring
// uses spmd_pkg, spmd_ctrl, spmd_datapath
//
// port group  dir  transfer carries
// s_axis      in   a_start xyz, a_end xyz, b_start xyz, b_end xyz
// m_axis      out  min_dist_sq, dist_ceil, rounds_exhausted
// apb         in   delta_step at 0x0, zero_cut_sq at 0x4
//
// one item at a time; a distance evaluation takes six steps per axis, a search up to
// 20 levels (step of one), and an item up to MAX_ROUNDS rounds plus endpoint seeding
// and rounding. reset is synchronous and needs no clearing pass.
// a finished result waits in the output register and the next item is taken meanwhile.

module segment_pair_min_distance_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
    // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // min_dist_sq, dist_ceil, rounds_exhausted
    output logic [71:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [spmd_pkg::DEL_W-1:0] r_delta;
    logic [spmd_pkg::ZC_W-1:0]  r_zc;

    spmd_pkg::t_cvec   w_as, w_ae, w_bs, w_be;
    spmd_pkg::t_dp_cmd w_cmd;
    spmd_pkg::t_dp_sts w_sts;
    logic [spmd_pkg::SQ_W-1:0]   w_sq;
    logic [spmd_pkg::CEIL_W-1:0] w_ceil;
    logic                        w_exh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= spmd_pkg::DEL_W'(10);
            r_zc    <= spmd_pkg::ZC_W'(41943);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) r_zc    <= pwdata[spmd_pkg::ZC_W-1:0];
            else          r_delta <= pwdata[spmd_pkg::DEL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(r_zc) : 32'(r_delta);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_as[i] = s_axis_tdata[spmd_pkg::COORD_W*i +: spmd_pkg::COORD_W];
            w_ae[i] = s_axis_tdata[spmd_pkg::COORD_W*(3+i) +: spmd_pkg::COORD_W];
            w_bs[i] = s_axis_tdata[spmd_pkg::COORD_W*(6+i) +: spmd_pkg::COORD_W];
            w_be[i] = s_axis_tdata[spmd_pkg::COORD_W*(9+i) +: spmd_pkg::COORD_W];
        end
    end

    spmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    spmd_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_a_s    (w_as),
        .i_a_e    (w_ae),
        .i_b_s    (w_bs),
        .i_b_e    (w_be),
        .i_delta  (r_delta),
        .i_zc     (r_zc),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_min_sq (w_sq),
        .o_ceil   (w_ceil),
        .o_exh    (w_exh)
    );

    assign m_axis_tdata = 72'({w_exh, w_ceil, w_sq});

endmodule
